// ----- hdl/pcd_pkg.sv -----
// Shared types and constants for the PNG chunk deframer.
// Holds the section codes, chunk type codes and the structs passed between stages.
// No dependencies; the stages, top level and testbench refer to it by scoped names.
`default_nettype none

package pcd_pkg;

  typedef enum logic [2:0] {
    SEC_SIG   = 3'd0,
    SEC_LEN   = 3'd1,
    SEC_TYPE  = 3'd2,
    SEC_DATA  = 3'd3,
    SEC_CRC   = 3'd4,
    SEC_TRAIL = 3'd5
  } section_t;

  // Chunk type words with the first type byte in the low eight bits.
  localparam logic [31:0] TYPE_IHDR = 32'h5244_4849;
  localparam logic [31:0] TYPE_IEND = 32'h444e_4549;

  localparam logic [31:0] SIG_LAST_INDEX   = 32'd7;
  localparam logic [31:0] FIELD_LAST_INDEX = 32'd3;
  localparam logic [2:0]  SIZE_LAST_INDEX  = 3'd7;

  typedef struct packed {
    logic       advance;
    logic [7:0] data;
  } stage_ctl_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  section;
    logic        chunk_last;
    logic        stream_last;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        size_valid;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/pcd_if.sv -----
// Valid/ready channel interfaces for the input byte stream and the tagged results.
// Depends on nothing; used by the top level of the PNG chunk deframer.
`default_nettype none

interface pcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface pcd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [2:0]  section;
  logic        chunk_last;
  logic        stream_last;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic        size_valid;

  modport source (
    output valid, output data_byte, output section, output chunk_last,
    output stream_last, output image_width, output image_height, output size_valid,
    input ready
  );
  modport sink (
    input valid, input data_byte, input section, input chunk_last,
    input stream_last, input image_width, input image_height, input size_valid,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/pcd_in_stage.sv -----
// Input register of the deframer: holds one accepted byte until the parser takes it.
// Depends on pcd_pkg for the stage control struct.
`default_nettype none

module pcd_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_data,
  output logic                    in_ready,
  input  wire logic               out_free,
  output pcd_pkg::stage_ctl_t     ctl
);

  logic       valid;
  logic [7:0] data;
  logic       advance;

  assign advance  = valid && out_free;
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

  assign ctl.advance = advance;
  assign ctl.data    = data;

endmodule

`default_nettype wire

// ----- hdl/pcd_parser.sv -----
// Section tracker and IHDR size capture; updates its state once per byte that advances.
// Depends on pcd_pkg for section codes, chunk type codes and the stage structs.
`default_nettype none

module pcd_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pcd_pkg::stage_ctl_t ctl,
  output pcd_pkg::result_t        res
);

  pcd_pkg::section_t phase;
  pcd_pkg::section_t phase_next;
  pcd_pkg::section_t sec;

  logic [31:0] byte_counter;
  logic [31:0] byte_counter_next;
  logic [31:0] length_word;
  logic [31:0] length_word_next;
  logic [31:0] type_word;
  logic [31:0] type_word_next;
  logic [31:0] width_word;
  logic [31:0] width_word_next;
  logic [31:0] height_word;
  logic [31:0] height_word_next;
  logic        in_header_chunk;
  logic        in_header_chunk_next;
  logic        in_end_chunk;
  logic        in_end_chunk_next;
  logic        size_captured;
  logic        size_captured_next;

  logic [7:0]  b;
  logic        cnt_ge3;
  logic        cnt_ge7;
  logic        data_end;
  logic        cap_size;
  logic        crc_done;

  assign b        = ctl.data;
  assign cnt_ge3  = byte_counter >= pcd_pkg::FIELD_LAST_INDEX;
  assign cnt_ge7  = byte_counter >= pcd_pkg::SIG_LAST_INDEX;
  assign data_end = byte_counter >= (length_word - 32'd1);
  assign cap_size = in_header_chunk && !size_captured && (byte_counter < 32'd8);
  assign crc_done = (phase == pcd_pkg::SEC_CRC) && cnt_ge3;

  always_comb begin
    case (phase)
      pcd_pkg::SEC_SIG:  phase_next = cnt_ge7 ? pcd_pkg::SEC_LEN : pcd_pkg::SEC_SIG;
      pcd_pkg::SEC_LEN:  phase_next = cnt_ge3 ? pcd_pkg::SEC_TYPE : pcd_pkg::SEC_LEN;
      pcd_pkg::SEC_TYPE: begin
        if (!cnt_ge3) begin
          phase_next = pcd_pkg::SEC_TYPE;
        end else if (length_word == 32'd0) begin
          phase_next = pcd_pkg::SEC_CRC;
        end else begin
          phase_next = pcd_pkg::SEC_DATA;
        end
      end
      pcd_pkg::SEC_DATA: phase_next = data_end ? pcd_pkg::SEC_CRC : pcd_pkg::SEC_DATA;
      pcd_pkg::SEC_CRC: begin
        if (!cnt_ge3) begin
          phase_next = pcd_pkg::SEC_CRC;
        end else if (in_end_chunk) begin
          phase_next = pcd_pkg::SEC_TRAIL;
        end else begin
          phase_next = pcd_pkg::SEC_LEN;
        end
      end
      default: phase_next = pcd_pkg::SEC_TRAIL;
    endcase
  end

  always_comb begin
    byte_counter_next    = byte_counter;
    length_word_next     = length_word;
    type_word_next       = type_word;
    width_word_next      = width_word;
    height_word_next     = height_word;
    in_header_chunk_next = in_header_chunk;
    in_end_chunk_next    = in_end_chunk;
    size_captured_next   = size_captured;
    case (phase)
      pcd_pkg::SEC_SIG: begin
        byte_counter_next = cnt_ge7 ? 32'd0 : byte_counter + 32'd1;
      end
      pcd_pkg::SEC_LEN: begin
        length_word_next  = {length_word[23:0], b};
        byte_counter_next = cnt_ge3 ? 32'd0 : byte_counter + 32'd1;
      end
      pcd_pkg::SEC_TYPE: begin
        type_word_next = {b, type_word[31:8]};
        if (cnt_ge3) begin
          in_header_chunk_next = (type_word_next == pcd_pkg::TYPE_IHDR);
          in_end_chunk_next    = (type_word_next == pcd_pkg::TYPE_IEND);
          if (in_header_chunk_next && !size_captured) begin
            width_word_next  = 32'd0;
            height_word_next = 32'd0;
          end
          byte_counter_next = 32'd0;
        end else begin
          byte_counter_next = byte_counter + 32'd1;
        end
      end
      pcd_pkg::SEC_DATA: begin
        if (cap_size) begin
          if (!byte_counter[2]) begin
            width_word_next = {width_word[23:0], b};
          end else begin
            height_word_next = {height_word[23:0], b};
          end
          if (byte_counter[2:0] == pcd_pkg::SIZE_LAST_INDEX) begin
            size_captured_next = 1'b1;
          end
        end
        byte_counter_next = data_end ? 32'd0 : byte_counter + 32'd1;
      end
      pcd_pkg::SEC_CRC: begin
        byte_counter_next = cnt_ge3 ? 32'd0 : byte_counter + 32'd1;
      end
      default: begin
        byte_counter_next = byte_counter;
      end
    endcase
  end

  always_comb begin
    case (phase)
      pcd_pkg::SEC_SIG:  sec = pcd_pkg::SEC_SIG;
      pcd_pkg::SEC_LEN:  sec = pcd_pkg::SEC_LEN;
      pcd_pkg::SEC_TYPE: sec = pcd_pkg::SEC_TYPE;
      pcd_pkg::SEC_DATA: sec = pcd_pkg::SEC_DATA;
      pcd_pkg::SEC_CRC:  sec = pcd_pkg::SEC_CRC;
      default:           sec = pcd_pkg::SEC_TRAIL;
    endcase
    res.data_byte    = b;
    res.section      = sec;
    res.chunk_last   = crc_done;
    res.stream_last  = crc_done && in_end_chunk;
    res.image_width  = size_captured_next ? width_word_next : 32'd0;
    res.image_height = size_captured_next ? height_word_next : 32'd0;
    res.size_valid   = size_captured_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= pcd_pkg::SEC_SIG;
      byte_counter    <= 32'd0;
      length_word     <= 32'd0;
      type_word       <= 32'd0;
      width_word      <= 32'd0;
      height_word     <= 32'd0;
      in_header_chunk <= 1'b0;
      in_end_chunk    <= 1'b0;
      size_captured   <= 1'b0;
    end else if (ctl.advance) begin
      phase           <= phase_next;
      byte_counter    <= byte_counter_next;
      length_word     <= length_word_next;
      type_word       <= type_word_next;
      width_word      <= width_word_next;
      height_word     <= height_word_next;
      in_header_chunk <= in_header_chunk_next;
      in_end_chunk    <= in_end_chunk_next;
      size_captured   <= size_captured_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pcd_out_stage.sv -----
// Result register of the deframer: holds one tagged byte until the sink takes it.
// Depends on pcd_pkg for the result struct.
`default_nettype none

module pcd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire pcd_pkg::result_t res_in,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output pcd_pkg::result_t      res_out,
  output logic                  out_free
);

  logic             valid;
  pcd_pkg::result_t payload;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign res_out   = payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      payload <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/png_chunk_deframer_top.sv -----
// Top level of the PNG chunk deframer: input register, section parser, result register.
// Depends on pcd_pkg, pcd_if, pcd_in_stage, pcd_parser and pcd_out_stage.
//
//   Channel   Role    Payload
//   stream    sink    in_byte (8)
//   result    source  data_byte, section, chunk_last, stream_last,
//                     image_width, image_height, size_valid
//
// One byte is taken per cycle while no result stalls; its result is registered from the parser.
// The rate is set by the single parser pass between the input and result registers.
// Reset is synchronous and returns the parser to the signature section with the size cleared.
// A stalled result holds the result register; the input register then fills and stream.ready
// drops until the result transfer frees a slot.
`default_nettype none

module png_chunk_deframer_top (
  input  wire logic    clk,
  input  wire logic    rst,
  pcd_byte_if.sink     stream,
  pcd_result_if.source result
);

  pcd_pkg::stage_ctl_t ctl;
  pcd_pkg::result_t    parsed;
  pcd_pkg::result_t    held;
  logic                out_free;
  logic                out_valid;

  pcd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_data  (stream.in_byte),
    .in_ready (stream.ready),
    .out_free (out_free),
    .ctl      (ctl)
  );

  pcd_parser u_parser (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (parsed)
  );

  pcd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.advance),
    .res_in    (parsed),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .res_out   (held),
    .out_free  (out_free)
  );

  assign result.valid        = out_valid;
  assign result.data_byte    = held.data_byte;
  assign result.section      = held.section;
  assign result.chunk_last   = held.chunk_last;
  assign result.stream_last  = held.stream_last;
  assign result.image_width  = held.image_width;
  assign result.image_height = held.image_height;
  assign result.size_valid   = held.size_valid;

  a_stream_last_ends_chunk: assert property (@(posedge clk) disable iff (rst)
    out_valid && held.stream_last |-> held.chunk_last)
    else $error("stream_last without chunk_last");

  a_chunk_last_in_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && held.chunk_last |-> held.section == pcd_pkg::SEC_CRC)
    else $error("chunk_last outside the CRC section");

  a_size_zero_until_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !held.size_valid |-> held.image_width == 32'd0 && held.image_height == 32'd0)
    else $error("image size shown before capture");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> stream.ready)
    else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire

// ----- verif/png_chunk_deframer_top_tb.sv -----
// Self-checking testbench for png_chunk_deframer_top: feeds PNG-like byte streams and
// checks every tagged result against an in-bench section tracker.
// Depends on pcd_pkg, the pcd_if interfaces and the deframer RTL.
`default_nettype none

module png_chunk_deframer_top_tb;

  localparam int unsigned IDLE_LIMIT = 500;

  logic clk;
  logic rst;
  bit gaps_on;
  bit stalls_on;
  int unsigned bytes_sent;
  int unsigned fail_count;
  int unsigned idle_cycles;
  pcd_pkg::result_t pending_results[$];

  pcd_pkg::section_t sec_now;
  logic [31:0] sec_count;
  logic [31:0] chunk_len;
  logic [31:0] type_acc;
  logic        type_is_ihdr;
  logic        type_is_iend;
  logic [31:0] cap_width;
  logic [31:0] cap_height;
  logic        size_done;

  pcd_byte_if stream_if ();
  pcd_result_if result_if ();

  png_chunk_deframer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic pcd_pkg::result_t deframe_byte(input logic [7:0] b);
    pcd_pkg::result_t r;
    pcd_pkg::section_t sec;
    sec = sec_now;
    r.chunk_last = 1'b0;
    r.stream_last = 1'b0;
    case (sec_now)
      pcd_pkg::SEC_SIG: begin
        if (sec_count >= 32'd7) begin
          sec_now = pcd_pkg::SEC_LEN;
          sec_count = 32'd0;
        end else begin
          sec_count = sec_count + 32'd1;
        end
      end
      pcd_pkg::SEC_LEN: begin
        chunk_len = {chunk_len[23:0], b};
        if (sec_count >= 32'd3) begin
          sec_now = pcd_pkg::SEC_TYPE;
          sec_count = 32'd0;
        end else begin
          sec_count = sec_count + 32'd1;
        end
      end
      pcd_pkg::SEC_TYPE: begin
        type_acc = {b, type_acc[31:8]};
        if (sec_count >= 32'd3) begin
          type_is_ihdr = (type_acc == pcd_pkg::TYPE_IHDR);
          type_is_iend = (type_acc == pcd_pkg::TYPE_IEND);
          if (type_is_ihdr && !size_done) begin
            cap_width = 32'd0;
            cap_height = 32'd0;
          end
          sec_count = 32'd0;
          sec_now = (chunk_len == 32'd0) ? pcd_pkg::SEC_CRC : pcd_pkg::SEC_DATA;
        end else begin
          sec_count = sec_count + 32'd1;
        end
      end
      pcd_pkg::SEC_DATA: begin
        if (type_is_ihdr && !size_done && sec_count < 32'd8) begin
          if (sec_count < 32'd4) cap_width = {cap_width[23:0], b};
          else cap_height = {cap_height[23:0], b};
          if (sec_count == 32'd7) size_done = 1'b1;
        end
        if (sec_count >= chunk_len - 32'd1) begin
          sec_now = pcd_pkg::SEC_CRC;
          sec_count = 32'd0;
        end else begin
          sec_count = sec_count + 32'd1;
        end
      end
      pcd_pkg::SEC_CRC: begin
        if (sec_count >= 32'd3) begin
          r.chunk_last = 1'b1;
          sec_count = 32'd0;
          if (type_is_iend) begin
            r.stream_last = 1'b1;
            sec_now = pcd_pkg::SEC_TRAIL;
          end else begin
            sec_now = pcd_pkg::SEC_LEN;
          end
        end else begin
          sec_count = sec_count + 32'd1;
        end
      end
      default: begin
        sec_now = pcd_pkg::SEC_TRAIL;
        sec = pcd_pkg::SEC_TRAIL;
      end
    endcase
    r.data_byte = b;
    r.section = sec;
    r.image_width = size_done ? cap_width : 32'd0;
    r.image_height = size_done ? cap_height : 32'd0;
    r.size_valid = size_done;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pcd_pkg::result_t want;
    if (!rst) begin
      if (stream_if.valid && stream_if.ready) begin
        pending_results.push_back(deframe_byte(stream_if.in_byte));
      end
      if (result_if.valid && result_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual data_byte %0h",
                   $time, result_if.data_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(result_if.data_byte));
          check_field("section", 32'(want.section), 32'(result_if.section));
          check_field("chunk_last", 32'(want.chunk_last), 32'(result_if.chunk_last));
          check_field("stream_last", 32'(want.stream_last), 32'(result_if.stream_last));
          check_field("image_width", want.image_width, result_if.image_width);
          check_field("image_height", want.image_height, result_if.image_height);
          check_field("size_valid", 32'(want.size_valid), 32'(result_if.size_valid));
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (stream_if.valid && stream_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("png_chunk_deframer_top regression: fail");
    $finish;
  end

  initial begin : result_sink
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    stream_if.valid <= 1'b1;
    stream_if.in_byte <= b;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  // The first eight data bytes come from size_bytes, the rest are random.
  task automatic send_chunk(input logic [31:0] len, input logic [31:0] ctype,
                            input logic [63:0] size_bytes);
    send_word(len);
    for (int i = 0; i < 4; i++) send_byte(ctype[8*i +: 8]);
    for (int unsigned d = 0; d < len; d++) begin
      if (d < 8) send_byte(size_bytes[63 - 8*d -: 8]);
      else send_byte(8'($urandom));
    end
    send_word($urandom);
  endtask

  task automatic wait_for_results;
    stream_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] random_type();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 9))
      0: t = pcd_pkg::TYPE_IHDR ^ (32'd1 << $urandom_range(0, 31));
      1: t = pcd_pkg::TYPE_IEND ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    if (t == pcd_pkg::TYPE_IHDR || t == pcd_pkg::TYPE_IEND) t = t ^ 32'h0000_0100;
    return t;
  endfunction

  task automatic send_random_chunk(input bit short_headers_only);
    gaps_on = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0, 1: send_chunk(32'd0, random_type(), {$urandom, $urandom});
      2: send_chunk(short_headers_only ? $urandom_range(0, 7) : $urandom_range(0, 16),
                    pcd_pkg::TYPE_IHDR, {$urandom, $urandom});
      default: send_chunk($urandom_range(1, 24), random_type(), {$urandom, $urandom});
    endcase
  endtask

  task automatic test_signature_and_empty_chunk;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_word(32'h8950_4E47);
    send_word(32'h0D0A_1A0A);
    send_chunk(32'd0, 32'h00FF_00FF, 64'd0);
  endtask

  task automatic test_short_header;
    send_chunk(32'd3, pcd_pkg::TYPE_IHDR, 64'hFF00_A55A_1234_5678);
    send_chunk(32'd0, pcd_pkg::TYPE_IHDR, 64'd0);
  endtask

  task automatic test_random_chunks(input int unsigned byte_goal, input bit short_headers_only);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      send_random_chunk(short_headers_only);
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic test_header_capture;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_chunk(32'd13, pcd_pkg::TYPE_IHDR, {32'hFFFF_FFFF, 32'h0000_0000});
  endtask

  task automatic test_repeated_header;
    send_chunk(32'd13, pcd_pkg::TYPE_IHDR, {$urandom, $urandom});
    send_chunk(32'd5, pcd_pkg::TYPE_IHDR, {$urandom, $urandom});
  endtask

  task automatic test_long_chunk;
    send_chunk($urandom_range(256, 600), random_type(), {$urandom, $urandom});
  endtask

  task automatic test_end_and_trailing;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_chunk($urandom_range(0, 4), pcd_pkg::TYPE_IEND, {$urandom, $urandom});
    repeat (40) send_byte(8'($urandom));
    send_chunk(32'd0, pcd_pkg::TYPE_IEND, 64'd0);
  endtask

  initial begin
    rst = 1'b1;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    bytes_sent = 0;
    fail_count = 0;
    sec_now = pcd_pkg::SEC_SIG;
    sec_count = 32'd0;
    chunk_len = 32'd0;
    type_acc = 32'd0;
    type_is_ihdr = 1'b0;
    type_is_iend = 1'b0;
    cap_width = 32'd0;
    cap_height = 32'd0;
    size_done = 1'b0;
    stream_if.valid = 1'b0;
    stream_if.in_byte = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_signature_and_empty_chunk();
    test_short_header();
    test_random_chunks(300, 1'b1);
    test_header_capture();
    test_repeated_header();
    test_random_chunks(400, 1'b0);
    test_long_chunk();
    test_end_and_trailing();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("png_chunk_deframer_top regression: pass");
    end else begin
      $display("png_chunk_deframer_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- png_chunk_deframer_top.f -----
hdl/pcd_pkg.sv
hdl/pcd_if.sv
hdl/pcd_in_stage.sv
hdl/pcd_parser.sv
hdl/pcd_out_stage.sv
hdl/png_chunk_deframer_top.sv
verif/png_chunk_deframer_top_tb.sv
